@@ rtl/core/tag_text_to_utf8_transcoder_macros.svh @@
// assertion macros shared by the transcoder rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef TAG_TEXT_TO_UTF8_TRANSCODER_MACROS_SVH
`define TAG_TEXT_TO_UTF8_TRANSCODER_MACROS_SVH
`ifndef ASSERT_OFF
`define TT2U_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TT2U_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TT2U_ASSERT(lbl, clk, rst, prop, msg)
`define TT2U_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/tt2u_pkg.sv @@
// types and constants of the text-to-utf8 transcoder
// no dependencies; used by every module of the block
`default_nettype none

package tt2u_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] out_position;
      logic       is_final;
      logic [7:0] final_length;
   } rsp_type;

   // one accepted byte turned into up to three utf-8 bytes and an optional closing beat
   typedef struct packed {
      logic [1:0]      byte_count;
      logic [2:0][7:0] bytes;
      logic [7:0]      start_pos;
      logic            is_final;
      logic [7:0]      final_length;
   } job_type;

   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam logic [8:0] CAPACITY_RESET = 9'd64;

   localparam logic [1:0] ENC_LATIN1  = 2'd0;
   localparam logic [1:0] ENC_UTF16   = 2'd1;
   localparam logic [1:0] ENC_UTF16BE = 2'd2;
   localparam logic [1:0] ENC_UTF8    = 2'd3;

   localparam logic [15:0] UNIT_BOM  = 16'hFEFF;
   localparam logic [15:0] SURR_LO   = 16'hD800;
   localparam logic [15:0] SURR_HI   = 16'hDFFF;
   localparam logic [15:0] LIMIT_1B  = 16'h0080;
   localparam logic [15:0] LIMIT_2B  = 16'h0800;
   localparam logic [7:0]  LEAD_2B   = 8'hC0;
   localparam logic [7:0]  LEAD_3B   = 8'hE0;
   localparam logic [7:0]  CONT_BYTE = 8'h80;
   localparam logic [7:0]  QMARK     = 8'h3F;
   localparam logic [7:0]  BOM_FE    = 8'hFE;
   localparam logic [7:0]  BOM_FF    = 8'hFF;
   localparam logic [7:0]  ASCII_SP  = 8'h20;
   localparam logic [7:0]  ASCII_TAB = 8'h09;

endpackage

`default_nettype wire

@@ rtl/core/tt2u_front.sv @@
// front end: takes input beats, tracks frame and encoding state, builds utf-8 jobs
// depends on tt2u_pkg and the transcoder macro header
`default_nettype none
`include "tag_text_to_utf8_transcoder_macros.svh"

module tt2u_front #(
   parameter int CAPACITY_LIMIT = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic             full,
   input  wire tt2u_pkg::req_type req_data,
   input  wire logic             valid,
   input  wire logic [8:0]       csr_data,
   output logic                  job_wr,
   output tt2u_pkg::job_type     job
);

   localparam int CW  = (CAPACITY_LIMIT > 1) ? $clog2(CAPACITY_LIMIT) : 1;
   localparam int CPW = (CW + 2 > 9) ? CW + 2 : 9;

   logic [8:0]    cap_cfg_ff;
   logic [1:0]    enc_ff, enc_in;
   logic          known_ff, known_in;
   logic          bom_ff, bom_in;
   logic          be_ff, be_in;
   logic [7:0]    held_ff, held_in;
   logic          held_vld_ff, held_vld_in;
   logic          skip_ff, skip_in;
   logic          stop_ff, stop_in;
   logic [CW-1:0] wcnt_ff, wcnt_in;
   logic [CW-1:0] kept_ff, kept_in, kept_mid;

   logic           acc;
   logic [7:0]     c;
   logic [15:0]    unit_cp;
   logic [CPW-1:0] cfg_w, cap_w, wcnt_w;
   logic           fit1, fit2, fit3;
   logic           ch_go, ch_raw, sur;
   logic [15:0]    cp;
   logic [1:0]     n;
   logic [2:0][7:0] b;

   assign acc     = push & ~full;
   assign c       = req_data.in_byte;
   assign unit_cp = be_ff ? {held_ff, c} : {c, held_ff};

   // effective capacity: zero acts as one, clamp to the limit
   always_comb begin
      cfg_w = CPW'(cap_cfg_ff);
      if (cfg_w == '0) begin
         cap_w = CPW'(1);
      end else if (cfg_w > CPW'(CAPACITY_LIMIT)) begin
         cap_w = CPW'(CAPACITY_LIMIT);
      end else begin
         cap_w = cfg_w;
      end
   end

   assign wcnt_w = CPW'(wcnt_ff);
   assign fit1   = (wcnt_w + CPW'(1)) < cap_w;
   assign fit2   = (wcnt_w + CPW'(2)) < cap_w;
   assign fit3   = (wcnt_w + CPW'(3)) < cap_w;

   always_comb begin
      enc_in      = enc_ff;
      known_in    = known_ff;
      bom_in      = bom_ff;
      be_in       = be_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      skip_in     = skip_ff;
      stop_in     = stop_ff;
      wcnt_in     = wcnt_ff;
      kept_mid    = kept_ff;
      kept_in     = kept_ff;
      ch_go       = 1'b0;
      ch_raw      = 1'b0;
      sur         = 1'b0;
      cp          = '0;
      n           = 2'd0;
      b           = '0;
      job         = '0;
      job_wr      = 1'b0;

      if (acc) begin
         if (req_data.first_byte) begin
            held_in     = '0;
            held_vld_in = 1'b0;
            skip_in     = 1'b0;
            wcnt_in     = '0;
            kept_mid    = '0;
            known_in    = 1'b1;
            enc_in      = c[1:0];
            stop_in     = |c[7:2];
            bom_in      = (c == 8'(tt2u_pkg::ENC_UTF16));
            be_in       = (c == 8'(tt2u_pkg::ENC_UTF16BE));
         end else if (known_ff && !stop_ff) begin
            unique case (enc_ff) inside
               tt2u_pkg::ENC_LATIN1: begin
                  if (c == 8'h00) begin
                     stop_in = 1'b1;
                  end else begin
                     ch_go = 1'b1;
                     cp    = {8'h00, c};
                  end
               end
               tt2u_pkg::ENC_UTF8: begin
                  if (c == 8'h00) begin
                     stop_in = 1'b1;
                  end else begin
                     ch_go  = 1'b1;
                     ch_raw = 1'b1;
                     cp     = {8'h00, c};
                  end
               end
               tt2u_pkg::ENC_UTF16, tt2u_pkg::ENC_UTF16BE: begin
                  if (held_vld_ff) begin
                     held_vld_in = 1'b0;
                     if (skip_ff) begin
                        skip_in = 1'b0;
                     end else if (bom_ff && held_ff == tt2u_pkg::BOM_FE &&
                                  c == tt2u_pkg::BOM_FF) begin
                        bom_in = 1'b0;
                        be_in  = 1'b1;
                     end else if (bom_ff && held_ff == tt2u_pkg::BOM_FF &&
                                  c == tt2u_pkg::BOM_FE) begin
                        bom_in = 1'b0;
                        be_in  = 1'b0;
                     end else begin
                        bom_in = 1'b0;
                        if (unit_cp == 16'h0000) begin
                           stop_in = 1'b1;
                        end else if (unit_cp == tt2u_pkg::UNIT_BOM) begin
                           stop_in = stop_ff;
                        end else if (unit_cp >= tt2u_pkg::SURR_LO &&
                                     unit_cp <= tt2u_pkg::SURR_HI) begin
                           skip_in = 1'b1;
                           sur     = 1'b1;
                        end else begin
                           ch_go = 1'b1;
                           cp    = unit_cp;
                        end
                     end
                  end else begin
                     held_in     = c;
                     held_vld_in = 1'b1;
                  end
               end
               default: begin
                  stop_in = stop_ff;
               end
            endcase
         end
      end

      // surrogate gives '?' only when it fits, and never stops
      if (sur && fit1) begin
         n    = 2'd1;
         b[0] = tt2u_pkg::QMARK;
      end

      if (ch_go) begin
         if (ch_raw || cp < tt2u_pkg::LIMIT_1B) begin
            if (fit1) begin
               n    = 2'd1;
               b[0] = cp[7:0];
            end else begin
               stop_in = 1'b1;
            end
         end else if (cp < tt2u_pkg::LIMIT_2B) begin
            if (fit2) begin
               n    = 2'd2;
               b[0] = tt2u_pkg::LEAD_2B | {3'b000, cp[10:6]};
               b[1] = tt2u_pkg::CONT_BYTE | {2'b00, cp[5:0]};
            end else begin
               stop_in = 1'b1;
            end
         end else begin
            if (fit3) begin
               n    = 2'd3;
               b[0] = tt2u_pkg::LEAD_3B | {4'h0, cp[15:12]};
               b[1] = tt2u_pkg::CONT_BYTE | {2'b00, cp[11:6]};
               b[2] = tt2u_pkg::CONT_BYTE | {2'b00, cp[5:0]};
            end else begin
               stop_in = 1'b1;
            end
         end
      end

      if (n != 2'd0) begin
         wcnt_in = wcnt_ff + CW'(n);
         // only a single ascii byte can be trailing white space
         if (!(n == 2'd1 && (b[0] == tt2u_pkg::ASCII_SP || b[0] == tt2u_pkg::ASCII_TAB))) begin
            kept_mid = wcnt_in;
         end
      end
      kept_in = kept_mid;

      job.byte_count = n;
      job.bytes      = b;
      job.start_pos  = 8'(wcnt_ff);

      if (acc && req_data.last_byte) begin
         job.is_final     = 1'b1;
         job.final_length = 8'(kept_mid);
         known_in         = 1'b0;
         stop_in          = 1'b0;
         held_vld_in      = 1'b0;
         skip_in          = 1'b0;
         bom_in           = 1'b0;
         wcnt_in          = '0;
         kept_in          = '0;
      end

      job_wr = acc && (n != 2'd0 || job.is_final);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_cfg_ff  <= tt2u_pkg::CAPACITY_RESET;
         enc_ff      <= '0;
         known_ff    <= 1'b0;
         bom_ff      <= 1'b0;
         be_ff       <= 1'b0;
         held_ff     <= '0;
         held_vld_ff <= 1'b0;
         skip_ff     <= 1'b0;
         stop_ff     <= 1'b0;
         wcnt_ff     <= '0;
         kept_ff     <= '0;
      end else begin
         if (valid) begin
            cap_cfg_ff <= csr_data;
         end
         enc_ff      <= enc_in;
         known_ff    <= known_in;
         bom_ff      <= bom_in;
         be_ff       <= be_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
         skip_ff     <= skip_in;
         stop_ff     <= stop_in;
         wcnt_ff     <= wcnt_in;
         kept_ff     <= kept_in;
      end
   end

   `TT2U_ASSERT(a_job_not_empty, clock, reset, job_wr |-> (job.byte_count != 2'd0 || job.is_final), "job with nothing to send")
   `TT2U_ASSERT_NEXT(a_frame_opens, clock, reset, acc && req_data.first_byte && !req_data.last_byte, known_ff && wcnt_ff == '0, "frame start did not open a frame")

endmodule

`default_nettype wire

@@ rtl/core/tt2u_queue.sv @@
// small job queue between front and back end
// depends on tt2u_pkg and the transcoder macro header
`default_nettype none
`include "tag_text_to_utf8_transcoder_macros.svh"

module tt2u_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire tt2u_pkg::job_type wr_data,
   output logic                   full,
   input  wire logic              rd_en,
   output tt2u_pkg::job_type      rd_data,
   output logic                   empty
);

   localparam int AW = tt2u_pkg::QUEUE_AW;

   tt2u_pkg::job_type mem_ff [tt2u_pkg::QUEUE_DEPTH];
   logic [AW-1:0]     wptr_ff, wptr_in;
   logic [AW-1:0]     rptr_ff, rptr_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign full    = (cnt_ff == (AW + 1)'(tt2u_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rptr_ff];
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;

   always_comb begin
      wptr_in = do_wr ? wptr_ff + AW'(1) : wptr_ff;
      rptr_in = do_rd ? rptr_ff + AW'(1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + (AW + 1)'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   `TT2U_ASSERT(a_no_write_when_full, clock, reset, full |-> !wr_en, "job written into a full queue")

endmodule

`default_nettype wire

@@ rtl/core/tt2u_back.sv @@
// back end: unrolls queued jobs into result beats through an output register
// depends on tt2u_pkg and the transcoder macro header
`default_nettype none
`include "tag_text_to_utf8_transcoder_macros.svh"

module tt2u_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire tt2u_pkg::job_type head,
   output logic                   q_rd,
   output logic                   empty,
   input  wire logic              pop,
   output tt2u_pkg::rsp_type      rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              out_vld_ff, out_vld_in;
   tt2u_pkg::rsp_type out_ff, out_in;
   logic [2:0]        pieces;
   logic              slot_free, step, last_piece;

   assign pieces     = {1'b0, head.byte_count} + {2'b00, head.is_final};
   assign slot_free  = ~out_vld_ff | pop;
   assign step       = ~q_empty & slot_free;
   assign last_piece = ({1'b0, idx_ff} + 3'd1) == pieces;
   assign q_rd       = step & last_piece;
   assign empty      = ~out_vld_ff;
   assign rsp_data   = out_ff;

   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      idx_in     = idx_ff;
      if (step) begin
         out_vld_in = 1'b1;
         idx_in     = last_piece ? 2'd0 : idx_ff + 2'd1;
         out_in     = '0;
         if (idx_ff < head.byte_count) begin
            out_in.out_byte     = head.bytes[idx_ff];
            out_in.out_position = head.start_pos + {6'b000000, idx_ff};
         end else begin
            // closing beat of the frame
            out_in.is_final     = 1'b1;
            out_in.final_length = head.final_length;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= 2'd0;
         out_vld_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
   end

   `TT2U_ASSERT(a_mid_job_has_head, clock, reset, idx_ff != 2'd0 |-> !q_empty, "job lost while partly sent")

endmodule

`default_nettype wire

@@ rtl/core/tag_text_to_utf8_transcoder.sv @@
// top level of the tag text frame to utf-8 transcoder
// depends on tt2u_pkg, tt2u_front, tt2u_queue and tt2u_back
//
//  channel   direction  handshake          payload
//  request   in         push / full        req_data (tt2u_pkg::req_type)
//  response  out        empty / pop        rsp_data (tt2u_pkg::rsp_type)
//  csr       in         valid / ready      csr_data (out_capacity, 9 bit)
//
// a request beat is taken every cycle while the 4-entry job queue has room
// the back end sends one result beat per cycle while pop keeps its output register free:
// a byte makes 0 to 3 utf-8 beats, plus one closing beat on the last byte
// a first result passes through the job queue and then the output register
// reset is synchronous; csr is always ready
`default_nettype none

module tag_text_to_utf8_transcoder #(
   parameter int CAPACITY_LIMIT = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire tt2u_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output tt2u_pkg::rsp_type      rsp_data,
   input  wire logic              valid,
   output logic                   ready,
   input  wire logic [8:0]        csr_data
);

   logic              job_wr;
   tt2u_pkg::job_type job;
   tt2u_pkg::job_type head;
   logic              q_full, q_empty, q_rd;

   assign full  = q_full;
   assign ready = 1'b1;

   tt2u_front #(
      .CAPACITY_LIMIT(CAPACITY_LIMIT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (q_full),
      .req_data (req_data),
      .valid    (valid),
      .csr_data (csr_data),
      .job_wr   (job_wr),
      .job      (job)
   );

   tt2u_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_wr),
      .wr_data (job),
      .full    (q_full),
      .rd_en   (q_rd),
      .rd_data (head),
      .empty   (q_empty)
   );

   tt2u_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head),
      .q_rd     (q_rd),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
